// File: rtl/e2s_pkg.sv
// ----------------------------------------------------------------------------
// e2s_pkg
// shared constants, width helpers and the result beat layout of the 2x2
// eigen solver
// ----------------------------------------------------------------------------
package e2s_pkg;

	localparam int ENTRY_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int OUT_W           = 20;
	localparam int DISC_MAX_W      = 64;

	// discriminant width, held to the 64-bit datapath
	function automatic int disc_w(input int w);
		int full;
		full = 2 * w + 3;
		return (full > DISC_MAX_W) ? DISC_MAX_W : full;
	endfunction

	// bits of the floor root, one per cell
	function automatic int root_w(input int w);
		return disc_w(w) / 2;
	endfunction

	// width of trace plus or minus root
	function automatic int val_w(input int w);
		int tw;
		int rw;
		tw = w + 1;
		rw = root_w(w);
		return ((tw > rw) ? tw : rw) + 1;
	endfunction

	typedef struct packed {
		logic                    complex_roots;
		logic signed [OUT_W-1:0] second_vec_y;
		logic signed [OUT_W-1:0] second_vec_x;
		logic signed [OUT_W-1:0] first_vec_y;
		logic signed [OUT_W-1:0] first_vec_x;
		logic signed [OUT_W-1:0] larger_eigenvalue;
		logic signed [OUT_W-1:0] smaller_eigenvalue;
	} eig_result_t;

endpackage

// File: rtl/e2s_front.sv
// ----------------------------------------------------------------------------
// e2s_front
// input register, trace and products, determinant and square of trace,
// discriminant and radicand
// ----------------------------------------------------------------------------
module e2s_front import e2s_pkg::*; #(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  feed_valid,
	output logic                                  feed_ready,
	input  logic signed [ENTRY_WIDTH-1:0]         top_left,
	input  logic signed [ENTRY_WIDTH-1:0]         top_right,
	input  logic signed [ENTRY_WIDTH-1:0]         bottom_left,
	input  logic signed [ENTRY_WIDTH-1:0]         bottom_right,
	output logic                                  pass_valid,
	input  logic                                  pass_ready,
	output logic [2*root_w(ENTRY_WIDTH)-1:0]      pass_rad,
	output logic [5*ENTRY_WIDTH+1:0]              pass_side
);

	localparam int W       = ENTRY_WIDTH;
	localparam int TR_W    = W + 1;
	localparam int PROD_W  = 2 * W;
	localparam int DET_W   = 2 * W + 1;
	localparam int TRSQ_W  = 2 * W + 2;
	localparam int FULL_W  = 2 * W + 3;
	localparam int DISC_W  = disc_w(W);
	localparam int RAD_W   = 2 * root_w(W);
	localparam int SIDE_W  = 5 * W + 2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [W-1:0]      a_s1, b_s1, c_s1, d_s1;
	logic signed [W-1:0]      a_s2, b_s2, c_s2, d_s2;
	logic signed [W-1:0]      a_s3, b_s3, c_s3, d_s3;
	logic signed [TR_W-1:0]   tr_s2, tr_s3;
	logic signed [PROD_W-1:0] ad_s2, bc_s2;
	logic signed [TRSQ_W-1:0] trsq_s3;
	logic signed [DET_W-1:0]  det_s3;
	logic [RAD_W-1:0]         rad_s4;
	logic [SIDE_W-1:0]        side_s4;

	logic signed [FULL_W-1:0] disc_full;
	logic [DISC_W-1:0]        disc;

	assign rdy_s4 = !v_s4 || pass_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign feed_ready = rdy_s1;
	assign pass_valid = v_s4;
	assign pass_rad   = rad_s4;
	assign pass_side  = side_s4;

	assign disc_full = FULL_W'(trsq_s3) - (FULL_W'(det_s3) <<< 2);
	assign disc      = disc_full[DISC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= feed_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			a_s1 <= top_left;
			b_s1 <= top_right;
			c_s1 <= bottom_left;
			d_s1 <= bottom_right;
		end
		if (rdy_s2) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			d_s2  <= d_s1;
			tr_s2 <= TR_W'(a_s1) + TR_W'(d_s1);
			ad_s2 <= PROD_W'(a_s1) * PROD_W'(d_s1);
			bc_s2 <= PROD_W'(b_s1) * PROD_W'(c_s1);
		end
		if (rdy_s3) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			c_s3    <= c_s2;
			d_s3    <= d_s2;
			tr_s3   <= tr_s2;
			trsq_s3 <= TRSQ_W'(tr_s2) * TRSQ_W'(tr_s2);
			det_s3  <= DET_W'(ad_s2) - DET_W'(bc_s2);
		end
		if (rdy_s4) begin
			rad_s4  <= RAD_W'(disc[DISC_W-2:0]);
			side_s4 <= {disc[DISC_W-1], tr_s3, a_s3, b_s3, c_s3, d_s3};
		end
	end

endmodule

// File: rtl/e2s_root_cell.sv
// ----------------------------------------------------------------------------
// e2s_root_cell
// one digit of the floor square root: shifts in two radicand bits, tries
// a subtract and appends one root bit
// ----------------------------------------------------------------------------
module e2s_root_cell #(
	parameter int ROOT_W = 17,
	parameter int RAD_W  = 34,
	parameter int SIDE_W = 82
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_valid,
	output logic              feed_ready,
	input  logic [RAD_W-1:0]  feed_rad,
	input  logic [ROOT_W+1:0] feed_rem,
	input  logic [ROOT_W-1:0] feed_root,
	input  logic [SIDE_W-1:0] feed_side,
	output logic              pass_valid,
	input  logic              pass_ready,
	output logic [RAD_W-1:0]  pass_rad,
	output logic [ROOT_W+1:0] pass_rem,
	output logic [ROOT_W-1:0] pass_root,
	output logic [SIDE_W-1:0] pass_side
);

	localparam int REM_W = ROOT_W + 2;

	logic              valid_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0] side_q;

	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] test;
	logic             take;

	assign trial = {feed_rem[ROOT_W-1:0], feed_rad[RAD_W-1 -: 2]};
	assign test  = {feed_root, 2'b01};
	assign take  = trial >= test;

	assign feed_ready = !valid_q || pass_ready;
	assign pass_valid = valid_q;
	assign pass_rad   = rad_q;
	assign pass_rem   = rem_q;
	assign pass_root  = root_q;
	assign pass_side  = side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (feed_ready) begin
			valid_q <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed_ready) begin
			rad_q  <= feed_rad << 2;
			rem_q  <= take ? (trial - test) : trial;
			root_q <= {feed_root[ROOT_W-2:0], take};
			side_q <= feed_side;
		end
	end

	// remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (rem_q <= {1'b0, root_q, 1'b0}))
		else $error("root cell remainder out of range");

endmodule

// File: rtl/e2s_back.sv
// ----------------------------------------------------------------------------
// e2s_back
// eigenvalues from trace and root, eigenvector selection and the output
// register
// ----------------------------------------------------------------------------
module e2s_back import e2s_pkg::*; #(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             feed_valid,
	output logic                             feed_ready,
	input  logic [root_w(ENTRY_WIDTH)-1:0]   feed_root,
	input  logic [5*ENTRY_WIDTH+1:0]         feed_side,
	output logic                             pass_valid,
	input  logic                             pass_ready,
	output eig_result_t                      pass_result
);

	localparam int W     = ENTRY_WIDTH;
	localparam int TR_W  = W + 1;
	localparam int VAL_W = val_w(W);
	localparam int VEC_W = VAL_W + 1;

	logic        valid_q;
	eig_result_t res_q;
	eig_result_t res_d;

	logic signed [W-1:0]     a, b, c, d;
	logic signed [TR_W-1:0]  tr;
	logic                    neg;
	logic signed [VAL_W-1:0] tr_x, root_x, lo_sum, hi_sum, lo_val, hi_val;
	logic signed [VEC_W-1:0] lo_d, hi_d, lo_a, hi_a;
	logic signed [OUT_W-1:0] unit;

	assign d   = feed_side[W-1:0];
	assign c   = feed_side[2*W-1:W];
	assign b   = feed_side[3*W-1:2*W];
	assign a   = feed_side[4*W-1:3*W];
	assign tr  = feed_side[5*W:4*W];
	assign neg = feed_side[5*W+1];

	assign tr_x   = VAL_W'(tr);
	assign root_x = VAL_W'(feed_root);
	assign lo_sum = tr_x - root_x;
	assign hi_sum = tr_x + root_x;
	assign lo_val = lo_sum >>> 1;
	assign hi_val = hi_sum >>> 1;
	assign lo_d   = VEC_W'(lo_val) - VEC_W'(d);
	assign hi_d   = VEC_W'(hi_val) - VEC_W'(d);
	assign lo_a   = VEC_W'(lo_val) - VEC_W'(a);
	assign hi_a   = VEC_W'(hi_val) - VEC_W'(a);
	assign unit   = {{(OUT_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	always_comb begin
		res_d = '0;
		if (neg) begin
			res_d.complex_roots = 1'b1;
		end else begin
			res_d.smaller_eigenvalue = OUT_W'(lo_val);
			res_d.larger_eigenvalue  = OUT_W'(hi_val);
			if (b == '0 && c == '0) begin
				res_d.first_vec_x  = unit;
				res_d.second_vec_y = unit;
			end else if (c != '0) begin
				res_d.first_vec_x  = OUT_W'(lo_d);
				res_d.first_vec_y  = OUT_W'(c);
				res_d.second_vec_x = OUT_W'(hi_d);
				res_d.second_vec_y = OUT_W'(c);
			end else begin
				res_d.first_vec_x  = OUT_W'(b);
				res_d.first_vec_y  = OUT_W'(lo_a);
				res_d.second_vec_x = OUT_W'(b);
				res_d.second_vec_y = OUT_W'(hi_a);
			end
		end
	end

	assign feed_ready  = !valid_q || pass_ready;
	assign pass_valid  = valid_q;
	assign pass_result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (feed_ready) begin
			valid_q <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed_ready) begin
			res_q <= res_d;
		end
	end

	a_complex_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.complex_roots |->
			(res_q.smaller_eigenvalue == '0) && (res_q.larger_eigenvalue == '0) &&
			(res_q.first_vec_x == '0) && (res_q.first_vec_y == '0) &&
			(res_q.second_vec_x == '0) && (res_q.second_vec_y == '0))
		else $error("complex beat carries nonzero data");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !neg |-> (hi_val >= lo_val))
		else $error("larger eigenvalue below smaller one");

endmodule

// File: rtl/eigen_2x2_solver_core.sv
// ----------------------------------------------------------------------------
// eigen_2x2_solver_core
// closed-form eigenvalues and eigenvectors of a stream of 2x2 fixed-point
// matrices
// ----------------------------------------------------------------------------
// One matrix is taken per clock and one result beat leaves per clock while
// m_axis_tready stays high; R is the number of root bits (17 at 16-bit
// entries). The floor square root is a row of R cells that each settle one
// root bit; front stages before it form trace, products, determinant and
// discriminant, and an output stage after it picks eigenvalues and
// eigenvectors. Every stage holds its own valid bit, so bubbles close up and
// the input stays ready while a finished beat waits at the output as long as
// some stage further down is empty; once all 5 + R stages hold a beat, a
// stalled output stalls the input. A negative discriminant gives tuser high
// and all data zero.
module eigen_2x2_solver_core import e2s_pkg::*; #(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int IN_TDATA_W = ((4 * ENTRY_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// top_left, top_right, bottom_left, bottom_right
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// smaller_eigenvalue, larger_eigenvalue, first_vec_x, first_vec_y,
	// second_vec_x, second_vec_y
	output logic [6*OUT_W-1:0]    m_axis_tdata,
	// complex_roots
	output logic                  m_axis_tuser
);

	localparam int W      = ENTRY_WIDTH;
	localparam int ROOT_W = root_w(W);
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int SIDE_W = 5 * W + 2;

	logic              cv    [0:ROOT_W];
	logic              cr    [0:ROOT_W];
	logic [RAD_W-1:0]  crad  [0:ROOT_W];
	logic [REM_W-1:0]  crem  [0:ROOT_W];
	logic [ROOT_W-1:0] croot [0:ROOT_W];
	logic [SIDE_W-1:0] cside [0:ROOT_W];

	eig_result_t result;

	e2s_front #(
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (s_axis_tvalid),
		.feed_ready   (s_axis_tready),
		.top_left     (s_axis_tdata[W-1:0]),
		.top_right    (s_axis_tdata[2*W-1:W]),
		.bottom_left  (s_axis_tdata[3*W-1:2*W]),
		.bottom_right (s_axis_tdata[4*W-1:3*W]),
		.pass_valid   (cv[0]),
		.pass_ready   (cr[0]),
		.pass_rad     (crad[0]),
		.pass_side    (cside[0])
	);

	assign crem[0]  = '0;
	assign croot[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		e2s_root_cell #(
			.ROOT_W (ROOT_W),
			.RAD_W  (RAD_W),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.feed_valid (cv[i]),
			.feed_ready (cr[i]),
			.feed_rad   (crad[i]),
			.feed_rem   (crem[i]),
			.feed_root  (croot[i]),
			.feed_side  (cside[i]),
			.pass_valid (cv[i+1]),
			.pass_ready (cr[i+1]),
			.pass_rad   (crad[i+1]),
			.pass_rem   (crem[i+1]),
			.pass_root  (croot[i+1]),
			.pass_side  (cside[i+1])
		);
	end

	e2s_back #(
		.ENTRY_WIDTH (ENTRY_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed_valid  (cv[ROOT_W]),
		.feed_ready  (cr[ROOT_W]),
		.feed_root   (croot[ROOT_W]),
		.feed_side   (cside[ROOT_W]),
		.pass_valid  (m_axis_tvalid),
		.pass_ready  (m_axis_tready),
		.pass_result (result)
	);

	assign m_axis_tdata = {result.second_vec_y, result.second_vec_x,
		result.first_vec_y, result.first_vec_x,
		result.larger_eigenvalue, result.smaller_eigenvalue};
	assign m_axis_tuser = result.complex_roots;

	// the root cell chain finishes with a remainder no larger than twice the root
	a_final_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cv[ROOT_W] |-> (crem[ROOT_W] <= {1'b0, croot[ROOT_W], 1'b0})
			&& (crad[ROOT_W] == '0))
		else $error("root chain left radicand bits unused");

endmodule
